/* hw/rtl/nmc_pkg.sv */
// Shared types and constants for the neighbour max clamp filter.
`timescale 1ns / 1ps

package nmc_pkg;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_PIXEL_BITS   = 16;
    localparam int MAX_HEIGHT       = 4096;
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int QUEUE_DEPTH      = 4;

    localparam int PIX_W        = 16;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 12;

    // Item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_row;
        logic             end_of_frame;
    } t_out_item;

    // Which neighbours exist for one output pixel, plus its raster markers.
    typedef struct packed {
        logic has_top;
        logic has_left;
        logic has_right;
        logic has_bottom;
        logic end_of_row;
        logic end_of_frame;
    } t_job_flags;

endpackage

/* hw/rtl/nmc_queue.sv */
// Small register queue that carries output jobs from the front to the back.
`timescale 1ns / 1ps

module nmc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = nmc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CNTW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
        end
        if (i_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");
`endif

endmodule

/* hw/rtl/nmc_front.sv */
// Front end: accepts items, tracks raster positions and issues output jobs.
`timescale 1ns / 1ps

module nmc_front #(
    parameter int MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nmc_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    input  nmc_pkg::t_in_item                   i_in_item,
    input  logic                                i_q_full,
    output logic                                o_in_stall,
    output logic                                o_wr_en,
    output logic [$clog2(2*MAX_WIDTH+nmc_pkg::QUEUE_DEPTH+2)-1:0] o_wr_addr,
    output logic [PIXEL_BITS-1:0]               o_wr_data,
    output logic                                o_push,
    output logic [$clog2(2*MAX_WIDTH+nmc_pkg::QUEUE_DEPTH+2)-1:0] o_job_addr,
    output nmc_pkg::t_job_flags                 o_job_flags,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      o_eff_w
);

    localparam int MEM_AW = $clog2(2*MAX_WIDTH + nmc_pkg::QUEUE_DEPTH + 2);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PW     = $clog2(MAX_WIDTH + 3);
    localparam int HW     = nmc_pkg::HEIGHT_REG_W;
    localparam int RW     = nmc_pkg::ROW_W;
    localparam int CMPW   = (WW > nmc_pkg::WIDTH_REG_W) ? WW : nmc_pkg::WIDTH_REG_W;
    localparam int EXT_W  = (PIXEL_BITS > nmc_pkg::PIX_W) ? PIXEL_BITS : nmc_pkg::PIX_W;
    localparam int RST_W  = (nmc_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                            MAX_WIDTH : nmc_pkg::RST_FRAME_WIDTH;

    logic [WW-1:0]     r_eff_w;
    logic [HW-1:0]     r_eff_h;
    logic [CW-1:0]     r_in_col, r_out_col;
    logic [RW-1:0]     r_in_row, r_out_row;
    logic [PW-1:0]     r_pending;
    logic [MEM_AW-1:0] r_wp, r_rp;

    logic              acc;
    logic              is_pix;
    logic              emit;
    logic              in_col_last, in_row_last;
    logic              out_col_last, out_row_last;
    logic [PW-1:0]     pend_inc;
    logic [PW-1:0]     w_plus1;
    logic [CMPW-1:0]   cfg_w_raw;
    logic [WW-1:0]     cfg_w_eff;
    logic [HW-1:0]     cfg_h_eff;
    logic [EXT_W-1:0]  pix_ext;

    // Items wait while a register is written, so a write never meets a transfer.
    assign o_in_stall = i_q_full || i_cfg_we;
    assign acc        = i_in_valid && !o_in_stall;
    assign is_pix     = (i_in_item.command == nmc_pkg::CMD_PIXEL);

    assign in_col_last  = (WW'(r_in_col) + WW'(1)) >= r_eff_w;
    assign in_row_last  = (HW'(r_in_row) + HW'(1)) >= r_eff_h;
    assign out_col_last = (WW'(r_out_col) + WW'(1)) >= r_eff_w;
    assign out_row_last = (HW'(r_out_row) + HW'(1)) >= r_eff_h;

    assign pend_inc = r_pending + PW'(1);
    assign w_plus1  = PW'(r_eff_w) + PW'(1);

    // A pixel releases an output once a full row plus one pixel sits behind
    // it; a drain releases one only after the whole frame has arrived.
    always_comb begin
        if (is_pix) begin
            emit = acc && (pend_inc > w_plus1);
        end else begin
            emit = acc && (r_in_col == '0) && (r_in_row == '0) && (r_pending != '0);
        end
    end

    // Clamp written sizes into the supported range.
    always_comb begin
        cfg_w_raw = CMPW'(i_cfg_data[nmc_pkg::WIDTH_REG_W-1:0]);
        if (cfg_w_raw == '0) begin
            cfg_w_eff = WW'(1);
        end else if (cfg_w_raw > CMPW'(MAX_WIDTH)) begin
            cfg_w_eff = WW'(MAX_WIDTH);
        end else begin
            cfg_w_eff = cfg_w_raw[WW-1:0];
        end
        if (i_cfg_data == '0) begin
            cfg_h_eff = HW'(1);
        end else if (i_cfg_data > HW'(nmc_pkg::MAX_HEIGHT)) begin
            cfg_h_eff = HW'(nmc_pkg::MAX_HEIGHT);
        end else begin
            cfg_h_eff = i_cfg_data;
        end
    end

    assign pix_ext   = EXT_W'(i_in_item.pixel_in);
    assign o_wr_en   = acc && is_pix;
    assign o_wr_addr = r_wp;
    assign o_wr_data = pix_ext[PIXEL_BITS-1:0];

    assign o_push     = emit;
    assign o_job_addr = r_rp;
    assign o_eff_w    = r_eff_w;

    always_comb begin
        o_job_flags.has_top      = (r_out_row != '0);
        o_job_flags.has_left     = (r_out_col != '0);
        o_job_flags.has_right    = !out_col_last;
        o_job_flags.has_bottom   = !out_row_last;
        o_job_flags.end_of_row   = out_col_last;
        o_job_flags.end_of_frame = out_col_last && out_row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= WW'(RST_W);
            r_eff_h   <= HW'(nmc_pkg::RST_FRAME_HEIGHT);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
        end else if (i_cfg_we) begin
            // Any register write restarts the frame and drops pending outputs.
            unique case (i_cfg_index)
                nmc_pkg::CFG_FRAME_WIDTH: begin
                    r_eff_w <= cfg_w_eff;
                end
                nmc_pkg::CFG_FRAME_HEIGHT: begin
                    r_eff_h <= cfg_h_eff;
                end
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
            r_rp      <= r_wp;
        end else if (acc) begin
            if (is_pix) begin
                r_wp <= r_wp + MEM_AW'(1);
                if (in_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= in_row_last ? '0 : r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (!emit) begin
                    r_pending <= pend_inc;
                end
            end else if (emit) begin
                r_pending <= r_pending - PW'(1);
            end
            if (emit) begin
                r_rp <= r_rp + MEM_AW'(1);
                if (out_col_last) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_last ? '0 : r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= w_plus1)
        else $error("more pixels pending than one row plus one");

    a_pointer_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == MEM_AW'(r_pending))
        else $error("store pointers disagree with pending count");
`endif

endmodule

/* hw/rtl/nmc_back.sv */
// Back end: pixel store, neighbour reads, clamp and output register.
`timescale 1ns / 1ps

module nmc_back #(
    parameter int MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nmc_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [$clog2(2*MAX_WIDTH+nmc_pkg::QUEUE_DEPTH+2)-1:0] i_wr_addr,
    input  logic [PIXEL_BITS-1:0]               i_wr_data,
    input  logic                                i_q_valid,
    input  logic [$clog2(2*MAX_WIDTH+nmc_pkg::QUEUE_DEPTH+2)-1:0] i_job_addr,
    input  nmc_pkg::t_job_flags                 i_job_flags,
    output logic                                o_q_pop,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_eff_w,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nmc_pkg::t_out_item                  o_out_item
);

    localparam int MEM_AW    = $clog2(2*MAX_WIDTH + nmc_pkg::QUEUE_DEPTH + 2);
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int EXT_W     = (PIXEL_BITS > nmc_pkg::PIX_W) ? PIXEL_BITS : nmc_pkg::PIX_W;

    // Three identical copies of the pixel store give five reads per job.
    logic [PIXEL_BITS-1:0] r_mem_vert [MEM_DEPTH];
    logic [PIXEL_BITS-1:0] r_mem_horz [MEM_DEPTH];
    logic [PIXEL_BITS-1:0] r_mem_cent [MEM_DEPTH];

    logic [MEM_AW-1:0]     addr_top, addr_bot, addr_left, addr_right;

    logic                  r_a_valid;
    nmc_pkg::t_job_flags   r_a_flags;
    logic [PIXEL_BITS-1:0] r_a_top, r_a_bot, r_a_left, r_a_right, r_a_cent;

    logic                  r_b_valid;
    logic [PIXEL_BITS-1:0] r_b_m1, r_b_m2, r_b_cent;
    logic                  r_b_have, r_b_eor, r_b_eof;

    logic                  r_out_valid;
    nmc_pkg::t_out_item    r_out_item;

    logic                  out_ready, b_ready, a_ready;
    logic                  b_load, out_load;
    logic [PIXEL_BITS-1:0] mt, ml, mr, mb, m1, m2;
    logic [PIXEL_BITS-1:0] best, clamped;
    logic [EXT_W-1:0]      clamped_ext;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign out_load  = r_b_valid && out_ready;
    assign b_ready   = !r_b_valid || out_ready;
    assign b_load    = r_a_valid && b_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign o_q_pop   = i_q_valid && a_ready;

    assign addr_top   = i_job_addr - MEM_AW'(i_eff_w);
    assign addr_bot   = i_job_addr + MEM_AW'(i_eff_w);
    assign addr_left  = i_job_addr - MEM_AW'(1);
    assign addr_right = i_job_addr + MEM_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_vert[i_wr_addr] <= i_wr_data;
        end
        if (o_q_pop) begin
            r_a_top <= r_mem_vert[addr_top];
            r_a_bot <= r_mem_vert[addr_bot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_horz[i_wr_addr] <= i_wr_data;
        end
        if (o_q_pop) begin
            r_a_left  <= r_mem_horz[addr_left];
            r_a_right <= r_mem_horz[addr_right];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_cent[i_wr_addr] <= i_wr_data;
        end
        if (o_q_pop) begin
            r_a_cent <= r_mem_cent[i_job_addr];
        end
    end

    // Missing neighbours read as zero; with at least one present the max is exact.
    always_comb begin
        mt = r_a_flags.has_top    ? r_a_top   : '0;
        ml = r_a_flags.has_left   ? r_a_left  : '0;
        mr = r_a_flags.has_right  ? r_a_right : '0;
        mb = r_a_flags.has_bottom ? r_a_bot   : '0;
        m1 = (mt > ml) ? mt : ml;
        m2 = (mr > mb) ? mr : mb;
    end

    always_comb begin
        best        = (r_b_m1 > r_b_m2) ? r_b_m1 : r_b_m2;
        clamped     = (r_b_have && (best < r_b_cent)) ? best : r_b_cent;
        clamped_ext = EXT_W'(clamped);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_flags <= i_job_flags;
        end
        if (b_load) begin
            r_b_m1   <= m1;
            r_b_m2   <= m2;
            r_b_cent <= r_a_cent;
            r_b_have <= r_a_flags.has_top || r_a_flags.has_left ||
                        r_a_flags.has_right || r_a_flags.has_bottom;
            r_b_eor  <= r_a_flags.end_of_row;
            r_b_eof  <= r_a_flags.end_of_frame;
        end
        if (out_load) begin
            r_out_item.pixel_out    <= clamped_ext[nmc_pkg::PIX_W-1:0];
            r_out_item.end_of_row   <= r_b_eor;
            r_out_item.end_of_frame <= r_b_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_pop_fills_read_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_a_valid)
        else $error("popped job did not reach the read stage");
`endif

endmodule

/* hw/rtl/neighbour_max_clamp_filter.sv */
// Top level of the 4-neighbour peak clamp filter.
// Throughput: one item per clock while the job queue has room and no register is being written.
// Job path: a job leaves the front with the item that releases it, waits in the job queue and
// then passes the registered stages store read, pair maximum and clamp into the output register.
// A pixel's result is released by the pixel one row plus one pixel after it, or by a drain once the frame is in.
// Reset (synchronous, active low) clears positions, counters, queue and valid flags;
// the pixel store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module neighbour_max_clamp_filter #(
    parameter int MAX_WIDTH  = nmc_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nmc_pkg::DEF_PIXEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  nmc_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output nmc_pkg::t_out_item             o_out_item
);

    localparam int MEM_AW = $clog2(2*MAX_WIDTH + nmc_pkg::QUEUE_DEPTH + 2);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int FLAG_W = $bits(nmc_pkg::t_job_flags);
    localparam int JOB_W  = MEM_AW + FLAG_W;

    logic                    wr_en;
    logic [MEM_AW-1:0]       wr_addr;
    logic [PIXEL_BITS-1:0]   wr_data;
    logic                    push, pop, q_full, q_valid;
    logic [MEM_AW-1:0]       job_addr;
    nmc_pkg::t_job_flags     job_flags;
    logic [JOB_W-1:0]        q_out;
    logic [WW-1:0]           eff_w;

    nmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_job_addr  (job_addr),
        .o_job_flags (job_flags),
        .o_eff_w     (eff_w)
    );

    nmc_queue #(
        .WIDTH (JOB_W),
        .DEPTH (nmc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({job_addr, job_flags}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    nmc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_q_valid   (q_valid),
        .i_job_addr  (q_out[JOB_W-1:FLAG_W]),
        .i_job_flags (nmc_pkg::t_job_flags'(q_out[FLAG_W-1:0])),
        .o_q_pop     (pop),
        .i_eff_w     (eff_w),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/nmc_clamp_checker.sv */
// Checker for the neighbour max clamp filter: predicts each clamped pixel and compares results.
`timescale 1ns / 1ps

module nmc_clamp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  nmc_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  nmc_pkg::t_out_item             i_out_item,
    output int                             o_outstanding,
    output int                             o_fail_count
);

    localparam int MAXW         = nmc_pkg::DEF_MAX_WIDTH;
    localparam int STORE_DEPTH  = 2 * MAXW + 3;
    localparam int PIX_W        = nmc_pkg::PIX_W;
    localparam int WIDTH_REG_W  = nmc_pkg::WIDTH_REG_W;
    localparam int HEIGHT_REG_W = nmc_pkg::HEIGHT_REG_W;

    // One circular pixel history models the filter's pixel store.
    logic [PIX_W-1:0]        pix_store [STORE_DEPTH];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int                      wr_ptr;
    int                      in_col;
    int                      in_row;
    int                      out_col;
    int                      out_row;
    int                      held;
    int                      fails = 0;
    nmc_pkg::t_out_item      expected_clamped [$];

    function automatic int frame_cols();
        int w;
        w = int'(width_reg);
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int frame_rows();
        int h;
        h = int'(height_reg);
        if (h == 0) h = 1;
        if (h > nmc_pkg::MAX_HEIGHT) h = nmc_pkg::MAX_HEIGHT;
        return h;
    endfunction

    // Pixel written 'back' transfers ago; 1 is the newest one.
    function automatic logic [PIX_W-1:0] look_back(input int back);
        int idx;
        idx = (wr_ptr - back) % STORE_DEPTH;
        if (idx < 0) idx += STORE_DEPTH;
        return pix_store[idx];
    endfunction

    function automatic void restart_raster();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        held    = 0;
    endfunction

    // The oldest held pixel is clamped to the largest of the neighbors that exist.
    function automatic void emit_clamped_pixel();
        int                 w;
        int                 h;
        logic [PIX_W-1:0]   centre;
        logic [PIX_W-1:0]   best;
        logic               found;
        logic [PIX_W-1:0]   nb [4];
        logic               ok [4];
        nmc_pkg::t_out_item res;
        w      = frame_cols();
        h      = frame_rows();
        centre = look_back(held);
        nb[0]  = look_back(held + w);
        ok[0]  = out_row > 0;
        nb[1]  = look_back(held + 1);
        ok[1]  = out_col > 0;
        nb[2]  = look_back(held - 1);
        ok[2]  = out_col + 1 < w;
        nb[3]  = look_back(held - w);
        ok[3]  = out_row + 1 < h;
        found  = 1'b0;
        best   = '0;
        for (int i = 0; i < 4; i++) begin
            if (ok[i] && (!found || nb[i] > best)) begin
                best  = nb[i];
                found = 1'b1;
            end
        end
        res.pixel_out    = (found && best < centre) ? best : centre;
        res.end_of_row   = out_col + 1 >= w;
        res.end_of_frame = (out_col + 1 >= w) && (out_row + 1 >= h);
        expected_clamped = {expected_clamped, res};
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        held--;
    endfunction

    function automatic void take_item(input nmc_pkg::t_in_item item);
        int w;
        int h;
        w = frame_cols();
        h = frame_rows();
        if (item.command == nmc_pkg::CMD_DRAIN) begin
            // A drain only releases output once the whole frame is in.
            if (in_col == 0 && in_row == 0 && held > 0) emit_clamped_pixel();
        end else begin
            pix_store[wr_ptr] = item.pixel_in;
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            held++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
            if (held > w + 1) emit_clamped_pixel();
        end
    endfunction

    task automatic check_field(input string name, input logic [PIX_W-1:0] want_v,
                               input logic [PIX_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        nmc_pkg::t_out_item want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_REG_W'(nmc_pkg::RST_FRAME_WIDTH);
            height_reg = HEIGHT_REG_W'(nmc_pkg::RST_FRAME_HEIGHT);
            wr_ptr     = 0;
            restart_raster();
            expected_clamped.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == nmc_pkg::CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                end else if (i_cfg_index == nmc_pkg::CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
                end
                restart_raster();
            end
            if (i_in_valid && !i_in_stall) take_item(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (expected_clamped.size() == 0) begin
                    $error("Unexpected result transfer: pixel_out %0h", i_out_item.pixel_out);
                    fails++;
                end else begin
                    want = expected_clamped.pop_front();
                    check_field("pixel_out", want.pixel_out, i_out_item.pixel_out);
                    check_field("end_of_row", PIX_W'(want.end_of_row),
                                PIX_W'(i_out_item.end_of_row));
                    check_field("end_of_frame", PIX_W'(want.end_of_frame),
                                PIX_W'(i_out_item.end_of_frame));
                end
            end
        end
        o_outstanding <= expected_clamped.size();
        o_fail_count  <= fails;
    end

endmodule

/* tb/neighbour_max_clamp_filter_tb.sv */
// Testbench top for the neighbour max clamp filter: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module neighbour_max_clamp_filter_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PIXELS = 480;
    localparam int PIX_W       = nmc_pkg::PIX_W;
    localparam int CFG_DATA_W  = nmc_pkg::CFG_DATA_W;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [nmc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    nmc_pkg::t_in_item              in_item;
    logic                           out_valid;
    logic                           out_stall;
    nmc_pkg::t_out_item             out_item;
    int                             outstanding;
    int                             fail_count;

    logic idle_on  = 1'b1;
    logic hold_req = 1'b0;
    int   tw;
    int   th;
    int   pixel_xfers   = 0;
    int   drain_xfers   = 0;
    int   results_seen  = 0;
    int   geometries    = 0;
    int   quiet_cycles  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    neighbour_max_clamp_filter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    nmc_clamp_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) results_seen <= results_seen + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Mostly a flat background with extremes and random spikes mixed in.
    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return PIX_W'($urandom);
            default: return PIX_W'($urandom_range(1000, 1010));
        endcase
    endfunction

    task automatic push_item(input logic cmd, input logic [PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_item  <= '{command: cmd, pixel_in: pix};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (cmd == nmc_pkg::CMD_PIXEL) pixel_xfers++;
        else drain_xfers++;
    endtask

    task automatic send_pixels(input int count, input logic noise);
        for (int i = 0; i < count; i++) begin
            if (noise && $urandom_range(0, 24) == 0) begin
                push_item(nmc_pkg::CMD_DRAIN, PIX_W'($urandom));
            end
            push_item(nmc_pkg::CMD_PIXEL, rand_pix());
        end
    endtask

    task automatic flush(input int count);
        for (int i = 0; i < count; i++) push_item(nmc_pkg::CMD_DRAIN, PIX_W'($urandom));
    endtask

    // Waits until every predicted result is out and the pipeline has run dry.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [nmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv);
        settle();
        write_reg(nmc_pkg::CFG_FRAME_WIDTH, wv);
        write_reg(nmc_pkg::CFG_FRAME_HEIGHT, hv);
        tw = int'(wv[nmc_pkg::WIDTH_REG_W-1:0]);
        if (tw == 0) tw = 1;
        if (tw > nmc_pkg::DEF_MAX_WIDTH) tw = nmc_pkg::DEF_MAX_WIDTH;
        th = int'(hv[nmc_pkg::HEIGHT_REG_W-1:0]);
        if (th == 0) th = 1;
        if (th > nmc_pkg::MAX_HEIGHT) th = nmc_pkg::MAX_HEIGHT;
        geometries++;
    endtask

    initial begin
        int   phase;
        int   frames;
        int   rand_end;
        logic broken;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = nmc_pkg::CFG_FRAME_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '{command: nmc_pkg::CMD_PIXEL, pixel_in: '0};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Drain right after reset has nothing to release.
        push_item(nmc_pkg::CMD_DRAIN, '1);

        // 3x3 frame with extremes and a drain in the middle of the frame.
        configure(3, 3);
        push_item(nmc_pkg::CMD_PIXEL, 16'h0000);
        push_item(nmc_pkg::CMD_PIXEL, 16'h1234);
        push_item(nmc_pkg::CMD_PIXEL, 16'hFFFF);
        push_item(nmc_pkg::CMD_PIXEL, 16'h00FF);
        push_item(nmc_pkg::CMD_DRAIN, 16'h5555);
        push_item(nmc_pkg::CMD_PIXEL, 16'hFFFF);
        push_item(nmc_pkg::CMD_PIXEL, 16'h7FFF);
        push_item(nmc_pkg::CMD_PIXEL, 16'hFFFF);
        push_item(nmc_pkg::CMD_PIXEL, 16'h0001);
        push_item(nmc_pkg::CMD_PIXEL, 16'h8000);
        flush(5);

        // A single-pixel frame has no neighbors; the drains push the held pixels out.
        configure(1, 1);
        push_item(nmc_pkg::CMD_PIXEL, 16'hFFFF);
        push_item(nmc_pkg::CMD_PIXEL, 16'h0000);
        flush(2);

        rand_end = pixel_xfers + RAND_PIXELS;
        phase    = 0;
        while (pixel_xfers < rand_end) begin
            if (pixel_xfers > rand_end - 90) idle_on = 1'b0;
            broken = 1'b0;
            case (phase)
                0: begin
                    // Zero registers fall back to a 1x1 frame.
                    configure(0, 0);
                    send_pixels(20, 1'b0);
                    flush(2);
                end
                1: begin
                    // Tallest frame, one column, abandoned part way through.
                    configure(1, 13'h1FFF);
                    send_pixels(60, 1'b1);
                end
                2: begin
                    configure(4, 8);
                    hold_req = 1'b1;
                    send_pixels(tw * th, 1'b0);
                    flush(tw + 2);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        configure(CFG_DATA_W'($urandom_range(9, 40)),
                                  CFG_DATA_W'($urandom_range(1, 3)));
                    end else begin
                        configure(CFG_DATA_W'($urandom_range(1, 8)),
                                  CFG_DATA_W'($urandom_range(1, 6)));
                    end
                    frames = $urandom_range(1, 3);
                    for (int f = 0; f < frames; f++) begin
                        if (f == frames - 1 && $urandom_range(0, 5) == 0) begin
                            send_pixels($urandom_range(1, tw * th), 1'b1);
                            broken = 1'b1;
                        end else begin
                            send_pixels(tw * th, 1'b1);
                            if (f < frames - 1 && $urandom_range(0, 1) == 1) begin
                                flush($urandom_range(0, tw + 1));
                            end
                        end
                    end
                    if (!broken) flush(tw + 1 + $urandom_range(0, 2));
                end
            endcase
            phase++;
        end

        // An oversized width register clamps to the maximum width; the
        // partial frame is dropped by the end of the run.
        idle_on = 1'b0;
        configure(13'h1FFF, 2);
        send_pixels(40, 1'b1);
        flush(2);

        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Checked %0d clamped pixels from %0d pixel and %0d drain transfers",
                 results_seen, pixel_xfers, drain_xfers);
        $display("over %0d frame geometries, from 1x1 frames to a 4096-row column.",
                 geometries);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* neighbour_max_clamp_filter.f */
hw/rtl/nmc_pkg.sv
hw/rtl/nmc_queue.sv
hw/rtl/nmc_front.sv
hw/rtl/nmc_back.sv
hw/rtl/neighbour_max_clamp_filter.sv
tb/nmc_clamp_checker.sv
tb/neighbour_max_clamp_filter_tb.sv
